// File: rtl/core/assert_macros.svh
// assertion macros for the sequencer rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DBRS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("sequencer assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DBRS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("sequencer assertion failed");

`endif

// File: rtl/core/dbrs_pkg.sv
// shared types, codes and helpers for the dma block ring sequencer
// no dependencies; used by dbrs_cfg, dbrs_engine and the top level
package dbrs_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int RING_W     = 5;   // holds 1..MAX_BLOCKS
	localparam int IDX_W      = 4;
	localparam int LEN_W      = 16;
	localparam int SAMPLES_W  = 17;

	typedef enum logic [2:0] {
		KIND_IRQ      = 3'd0,
		KIND_ADD      = 3'd1,
		KIND_ADD_LAST = 3'd2,
		KIND_START    = 3'd3,
		KIND_STOP     = 3'd4,
		KIND_RESET    = 3'd5,
		KIND_READ_OVR = 3'd6,
		KIND_QUERY    = 3'd7
	} kind_e;

	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_AUTO   = 3'd1,
		CMD_SINGLE = 3'd2,
		CMD_EXIT   = 3'd3,
		CMD_CONT   = 3'd4,
		CMD_PAUSE  = 3'd5
	} cmd_e;

	typedef enum logic [1:0] {
		TAIL_NONE  = 2'd0,
		TAIL_SHORT = 2'd1,
		TAIL_EMPTY = 2'd2
	} tail_e;

	typedef enum logic [1:0] {
		REG_RECORD    = 2'd0,
		REG_STEREO    = 2'd1,
		REG_BLOCK_LEN = 2'd2,
		REG_BLOCK_CNT = 2'd3
	} cfg_reg_e;

	typedef enum logic [9:0] {
		ST_AWAIT  = 10'b00_0000_0001,
		ST_WAIT1  = 10'b00_0000_0010,
		ST_WAIT1A = 10'b00_0000_0100,
		ST_WAIT2  = 10'b00_0000_1000,
		ST_WAIT3  = 10'b00_0001_0000,
		ST_WAIT4  = 10'b00_0010_0000,
		ST_WAIT5  = 10'b00_0100_0000,
		ST_WAIT6  = 10'b00_1000_0000,
		ST_WAIT6A = 10'b01_0000_0000,
		ST_BLOCK  = 10'b10_0000_0000
	} run_state_e;

	// settings seen by the engine, with derived values
	typedef struct packed {
		logic              record_mode;
		logic [LEN_W-1:0]  half_length;  // block_length / 2
		logic [RING_W-1:0] ring_n;       // block_count clamped to 1..MAX_BLOCKS
		logic [LEN_W-1:0]  auto_len;     // auto-init length minus one
	} cfg_t;

	typedef struct packed {
		kind_e                kind;
		logic                 irq_is_dma8;
		logic                 consumer_busy;
		logic [SAMPLES_W-1:0] last_length;
	} item_t;

	// input tdata layout, last field in the lowest bits
	typedef struct packed {
		logic [4:0]           pad;
		logic [SAMPLES_W-1:0] last_length;
		logic                 consumer_busy;
		logic                 irq_is_dma8;
	} in_data_t;

	// output tdata layout, last field in the lowest bits
	typedef struct packed {
		logic [4:0]        pad;
		logic              blocked;
		logic              stopped;
		logic [15:0]       overrun_count;
		logic [4:0]        queued_blocks;
		logic [IDX_W-1:0]  block_index;
		logic              rejected;
		logic              notify_last;
		logic              notify;
		logic              pass_on;
		logic              irq_ack;
		logic [LEN_W-1:0]  transfer_length;
		logic [2:0]        dsp_command;
	} result_t;

	// remainder of a small sum by the ring size, restoring style, five narrow steps
	function automatic logic [IDX_W-1:0] ring_mod(input logic [RING_W-1:0] sum,
		input logic [RING_W-1:0] n);
		logic [8:0] r;
		logic [8:0] d;
		r = {4'b0, sum};
		for (int k = 4; k >= 0; k--) begin
			d = {4'b0, n} << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[IDX_W-1:0];
	endfunction

endpackage

// File: rtl/core/dma_block_ring_sequencer.sv
// the input register captures each event, and the result register loads from the engine once
// it is empty or being drained; the result transfer is offered from the result register
// throughput: one event per cycle unless the output is held; the ring state updates in a single
// pass of the engine logic, and the input register refills as the result register drains
// reset: asynchronous, clears both stages and puts the ring paused, awaiting, empty, no tail,
// zero overruns; configuration returns to playback, mono, block length 2, one block
// depends on dbrs_pkg, dbrs_cfg, dbrs_engine and assert_macros.svh
`include "assert_macros.svh"

module dma_block_ring_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // irq_is_dma8, consumer_busy, last_length[16:0], zero pad
	input  logic [2:0]  s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// dsp_command[2:0], transfer_length[15:0], irq_ack, pass_on, notify, notify_last,
	// rejected, block_index[3:0], queued_blocks[4:0], overrun_count[15:0], stopped, blocked,
	// zero pad
	output logic [55:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	dbrs_pkg::cfg_t     cfg;
	dbrs_pkg::item_t    item_s1;
	dbrs_pkg::in_data_t in_data;
	dbrs_pkg::result_t  result;
	dbrs_pkg::result_t  result_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               advance;
	logic               out_held;
	logic               last_ok;

	assign in_data       = s_axis_tdata;
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.kind          <= dbrs_pkg::kind_e'(s_axis_tuser);
			item_s1.irq_is_dma8   <= in_data.irq_is_dma8;
			item_s1.consumer_busy <= in_data.consumer_busy;
			item_s1.last_length   <= in_data.last_length;
		end
	end

	dbrs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dbrs_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

	assign out_held = valid_s2 && !m_axis_tready;
	assign last_ok  = result_s2.notify && result_s2.blocked && (result_s2.queued_blocks == 5'd0);

	// input side only stalls when both stages hold items and the output is held
	`DBRS_ASSERT_IMP(a_stall_only_when_full, clk, arst_n, !s_axis_tready, valid_s1 && out_held)
	`DBRS_ASSERT_NEXT(a_advance_loads_result, clk, arst_n, advance, valid_s2)
	`DBRS_ASSERT_IMP(a_last_notify_blocked, clk, arst_n, valid_s2 && result_s2.notify_last, last_ok)

endmodule

// File: rtl/core/dbrs_cfg.sv
// configuration registers of the sequencer and the values derived from them
// depends on dbrs_pkg
module dbrs_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [dbrs_pkg::SAMPLES_W-1:0] cfg_data,
	output dbrs_pkg::cfg_t                cfg
);

	logic                           record_q;
	logic                           stereo_q;
	logic [dbrs_pkg::SAMPLES_W-1:0] blen_q;
	logic [4:0]                     bcnt_q;
	logic [dbrs_pkg::SAMPLES_W-1:0] samples;
	logic [dbrs_pkg::SAMPLES_W-1:0] samples_m1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_q <= 1'b0;
			stereo_q <= 1'b0;
			blen_q   <= 17'd2;
			bcnt_q   <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dbrs_pkg::cfg_reg_e'(cfg_index))
				dbrs_pkg::REG_RECORD:    record_q <= cfg_data[0];
				dbrs_pkg::REG_STEREO:    stereo_q <= cfg_data[0];
				dbrs_pkg::REG_BLOCK_LEN: blen_q   <= cfg_data;
				dbrs_pkg::REG_BLOCK_CNT: bcnt_q   <= cfg_data[4:0];
			endcase
		end
	end

	// mono blocks move half the samples per dma byte count
	assign samples    = stereo_q ? blen_q : {1'b0, blen_q[dbrs_pkg::SAMPLES_W-1:1]};
	assign samples_m1 = samples - 17'd1;

	always_comb begin
		cfg.record_mode = record_q;
		cfg.half_length = blen_q[dbrs_pkg::SAMPLES_W-1:1];
		cfg.auto_len    = samples_m1[dbrs_pkg::LEN_W-1:0];
		if (bcnt_q == 5'd0) begin
			cfg.ring_n = 5'd1;
		end else if (bcnt_q > 5'(dbrs_pkg::MAX_BLOCKS)) begin
			cfg.ring_n = 5'(dbrs_pkg::MAX_BLOCKS);
		end else begin
			cfg.ring_n = bcnt_q;
		end
	end

endmodule

// File: rtl/core/dbrs_engine.sv
// ring state registers and the combinational event update
// depends on dbrs_pkg; fed by the input stage of the top level
module dbrs_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  dbrs_pkg::item_t   item,
	input  dbrs_pkg::cfg_t    cfg,
	output dbrs_pkg::result_t result
);

	typedef struct packed {
		logic                           rej;
		dbrs_pkg::run_state_e           st;
		logic                           paused;
		dbrs_pkg::cmd_e                 cmd;
		logic [dbrs_pkg::LEN_W-1:0]     xlen;
	} start_t;

	dbrs_pkg::run_state_e            st_q, st_d;
	logic                            paused_q, paused_d;
	logic [dbrs_pkg::IDX_W-1:0]      dma_q, dma_d;
	logic [dbrs_pkg::RING_W-1:0]     qc_q, qc_d;
	dbrs_pkg::tail_e                 tk_q, tk_d;
	logic [dbrs_pkg::LEN_W-1:0]      tl_q, tl_d;
	logic [15:0]                     ovr_q, ovr_d;

	dbrs_pkg::cmd_e                  cmd;
	logic [dbrs_pkg::LEN_W-1:0]      xlen;
	logic                            ack, pass, note, note_last, rej, up, full, blk;
	logic [dbrs_pkg::RING_W-1:0]     dma_inc;
	logic [dbrs_pkg::SAMPLES_W-1:0]  len_m1;
	start_t                          sr;

	function automatic start_t do_start(input dbrs_pkg::run_state_e st, input logic paused,
		input logic [dbrs_pkg::RING_W-1:0] qc, input dbrs_pkg::tail_e tk,
		input logic [dbrs_pkg::LEN_W-1:0] tl, input logic [dbrs_pkg::LEN_W-1:0] alen);
		start_t r;
		r.rej    = 1'b0;
		r.st     = st;
		r.paused = paused;
		r.cmd    = dbrs_pkg::CMD_NONE;
		r.xlen   = '0;
		if (!paused && st != dbrs_pkg::ST_AWAIT) begin
			r.rej = 1'b1;
		end else begin
			r.paused = 1'b0;
			if (st != dbrs_pkg::ST_AWAIT) begin
				r.cmd = dbrs_pkg::CMD_CONT;
			end else if (qc != '0) begin
				r.st   = dbrs_pkg::ST_WAIT1;
				r.cmd  = dbrs_pkg::CMD_AUTO;
				r.xlen = alen;
			end else if (tk == dbrs_pkg::TAIL_SHORT) begin
				r.st   = dbrs_pkg::ST_WAIT4;
				r.cmd  = dbrs_pkg::CMD_SINGLE;
				r.xlen = tl;
			end else if (tk == dbrs_pkg::TAIL_EMPTY) begin
				r.st = dbrs_pkg::ST_BLOCK;
			end
		end
		return r;
	endfunction

	assign dma_inc = {1'b0, dma_q} + 5'd1;
	assign len_m1  = item.last_length - 17'd1;
	assign full    = (qc_q >= cfg.ring_n) || (tk_q != dbrs_pkg::TAIL_NONE);

	always_comb begin
		st_d      = st_q;
		paused_d  = paused_q;
		dma_d     = dma_q;
		qc_d      = qc_q;
		tk_d      = tk_q;
		tl_d      = tl_q;
		ovr_d     = ovr_q;
		cmd       = dbrs_pkg::CMD_NONE;
		xlen      = '0;
		ack       = 1'b0;
		pass      = 1'b0;
		note      = 1'b0;
		note_last = 1'b0;
		rej       = 1'b0;
		up        = 1'b0;
		sr        = '0;

		unique case (item.kind)
			dbrs_pkg::KIND_IRQ: begin
				if (!item.irq_is_dma8) begin
					pass = 1'b1;
				end else if (!paused_q) begin
					unique case (st_q)
						dbrs_pkg::ST_WAIT1: begin
							if (qc_q > 5'd1) begin
								ack  = 1'b1;
								st_d = dbrs_pkg::ST_WAIT2;
							end else if (tk_q == dbrs_pkg::TAIL_NONE) begin
								st_d = dbrs_pkg::ST_WAIT1A;
							end else if (tk_q == dbrs_pkg::TAIL_SHORT) begin
								cmd  = dbrs_pkg::CMD_SINGLE;
								xlen = tl_q;
								ack  = 1'b1;
								st_d = dbrs_pkg::ST_WAIT3;
							end else begin
								cmd  = dbrs_pkg::CMD_EXIT;
								ack  = 1'b1;
								st_d = dbrs_pkg::ST_WAIT4;
							end
						end
						dbrs_pkg::ST_WAIT2: begin
							ack = 1'b1;
							if (qc_q != '0) begin
								qc_d = qc_q - 5'd1;
							end
							// ring wrap, also when the ring was shrunk under the dma index
							dma_d = (dma_inc >= cfg.ring_n) ? '0 : dma_inc[dbrs_pkg::IDX_W-1:0];
							st_d  = dbrs_pkg::ST_WAIT1;
							up    = 1'b1;
						end
						dbrs_pkg::ST_WAIT3: begin
							ack = 1'b1;
							if (qc_q != '0) begin
								qc_d = qc_q - 5'd1;
							end
							st_d = dbrs_pkg::ST_WAIT4;
							up   = 1'b1;
						end
						dbrs_pkg::ST_WAIT4: begin
							ack  = 1'b1;
							st_d = dbrs_pkg::ST_BLOCK;
							up   = 1'b1;
						end
						dbrs_pkg::ST_WAIT5: begin
							cmd  = dbrs_pkg::CMD_EXIT;
							ack  = 1'b1;
							st_d = dbrs_pkg::ST_WAIT4;
							up   = 1'b1;
						end
						dbrs_pkg::ST_WAIT6: begin
							ack  = 1'b1;
							st_d = dbrs_pkg::ST_WAIT6A;
							up   = 1'b1;
						end
						dbrs_pkg::ST_WAIT6A: begin
							cmd  = dbrs_pkg::CMD_EXIT;
							ack  = 1'b1;
							st_d = dbrs_pkg::ST_WAIT4;
						end
						default: begin
						end
					endcase
					if (up) begin
						if (item.consumer_busy) begin
							if (ovr_q != 16'hFFFF) begin
								ovr_d = ovr_q + 16'd1;
							end
						end else begin
							note      = 1'b1;
							note_last = (st_d == dbrs_pkg::ST_BLOCK);
						end
					end
				end
			end
			dbrs_pkg::KIND_ADD: begin
				if (full) begin
					rej = 1'b1;
				end else begin
					qc_d = qc_q + 5'd1;
					if (!paused_q && st_q == dbrs_pkg::ST_AWAIT) begin
						sr       = do_start(st_q, paused_q, qc_d, tk_q, tl_q, cfg.auto_len);
						st_d     = sr.st;
						paused_d = sr.paused;
						cmd      = sr.cmd;
						xlen     = sr.xlen;
					end else if (st_q == dbrs_pkg::ST_WAIT1A) begin
						st_d = dbrs_pkg::ST_WAIT2;
						ack  = 1'b1;
					end
				end
			end
			dbrs_pkg::KIND_ADD_LAST: begin
				if (full) begin
					rej = 1'b1;
				end else begin
					tk_d = (item.last_length != '0) ? dbrs_pkg::TAIL_SHORT : dbrs_pkg::TAIL_EMPTY;
					tl_d = len_m1[dbrs_pkg::LEN_W-1:0];
					if (!paused_q && st_q == dbrs_pkg::ST_AWAIT) begin
						sr       = do_start(st_q, paused_q, qc_q, tk_d, tl_d, cfg.auto_len);
						st_d     = sr.st;
						paused_d = sr.paused;
						cmd      = sr.cmd;
						xlen     = sr.xlen;
					end else if (st_q == dbrs_pkg::ST_WAIT1A) begin
						ack  = 1'b1;
						// a tail no longer than half a block gets the exit command at the next dma irq, a longer one an irq later
						st_d = (item.last_length <= {1'b0, cfg.half_length}) ?
							dbrs_pkg::ST_WAIT5 : dbrs_pkg::ST_WAIT6;
					end
				end
			end
			dbrs_pkg::KIND_START: begin
				sr       = do_start(st_q, paused_q, qc_q, tk_q, tl_q, cfg.auto_len);
				rej      = sr.rej;
				st_d     = sr.st;
				paused_d = sr.paused;
				cmd      = sr.cmd;
				xlen     = sr.xlen;
			end
			dbrs_pkg::KIND_STOP: begin
				cmd = dbrs_pkg::CMD_PAUSE;
				if (paused_q) begin
					rej = 1'b1;
				end else begin
					paused_d = 1'b1;
				end
			end
			dbrs_pkg::KIND_RESET: begin
				cmd      = dbrs_pkg::CMD_PAUSE;
				st_d     = dbrs_pkg::ST_AWAIT;
				paused_d = 1'b1;
				dma_d    = '0;
				qc_d     = cfg.record_mode ? cfg.ring_n : '0;
				tk_d     = dbrs_pkg::TAIL_NONE;
				tl_d     = '0;
				ovr_d    = '0;
			end
			dbrs_pkg::KIND_READ_OVR: begin
				ovr_d = '0;
			end
			dbrs_pkg::KIND_QUERY: begin
				rej = full;
			end
		endcase
	end

	assign blk = !paused_d && (st_d == dbrs_pkg::ST_BLOCK);

	always_comb begin
		result                 = '0;
		result.dsp_command     = cmd;
		result.transfer_length = xlen;
		result.irq_ack         = ack;
		result.pass_on         = pass;
		result.notify          = note;
		result.notify_last     = note_last;
		result.rejected        = rej;
		result.block_index     = dbrs_pkg::ring_mod({1'b0, dma_d} + qc_d, cfg.ring_n);
		result.queued_blocks   = blk ? '0 : qc_d + {4'b0, tk_d != dbrs_pkg::TAIL_NONE};
		// the overrun read reports the count before clearing
		result.overrun_count   = (item.kind == dbrs_pkg::KIND_READ_OVR) ? ovr_q : ovr_d;
		result.stopped         = paused_d;
		result.blocked         = blk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= dbrs_pkg::ST_AWAIT;
			paused_q <= 1'b1;
			dma_q    <= '0;
			qc_q     <= '0;
			tk_q     <= dbrs_pkg::TAIL_NONE;
			tl_q     <= '0;
			ovr_q    <= '0;
		end else if (fire) begin
			st_q     <= st_d;
			paused_q <= paused_d;
			dma_q    <= dma_d;
			qc_q     <= qc_d;
			tk_q     <= tk_d;
			tl_q     <= tl_d;
			ovr_q    <= ovr_d;
		end
	end

endmodule
